@@ rtl/bpc_pkg.sv @@
package bpc_pkg;

  // Pipeline depth: one register stage per entry, the last is the output register
  localparam int unsigned NumStages = 6;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWordOne   = 3'd0,
    CfgWordTwo   = 3'd1,
    CfgWordThree = 3'd2,
    CfgWordFour  = 3'd3
  } cfg_idx_e;

  // Unpacked calibration coefficients
  typedef struct packed {
    logic [14:0] c1;
    logic [10:0] c5;
    logic [5:0]  c6;
    logic [9:0]  c4;
    logic [11:0] c2;
    logic [9:0]  c3;
  } coeff_t;

  // Per-stage load strobes from the handshake control to the datapath
  typedef struct packed {
    logic [NumStages-1:0] load;
  } pipe_ctrl_t;

  // Compensation constants
  localparam logic [15:0]        RefTempBase  = 16'd20224;
  localparam logic signed [17:0] SensBase     = 18'sd24576;
  localparam logic signed [16:0] PressRawBase = 17'sd7168;
  localparam logic signed [18:0] PressBase    = 19'sd2500;
  localparam logic signed [18:0] PressKnee    = 19'sd3500;
  localparam logic signed [15:0] TempBase     = 16'sd200;
  localparam logic [6:0]         TempSlopeOff = 7'd50;
  localparam logic [6:0]         CorrSlopeOff = 7'd24;
  localparam logic [9:0]         CorrGain     = 10'd11;

  // Output ranges
  localparam logic signed [25:0] PressMax = 26'sd8388607;
  localparam logic signed [25:0] PressMin = -26'sd8388608;
  localparam logic signed [16:0] TempMax  = 17'sd32767;
  localparam logic signed [16:0] TempMin  = -17'sd32768;

endpackage

@@ rtl/bpc_cfg.sv @@
module bpc_cfg import bpc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output coeff_t              coeff_o
);

  logic [15:0] w1_q, w2_q, w3_q, w4_q;

  // Store calibration words; drop writes to unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w1_q <= '0;
      w2_q <= '0;
      w3_q <= '0;
      w4_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgWordOne:   w1_q <= cfg_wdata_i;
        CfgWordTwo:   w2_q <= cfg_wdata_i;
        CfgWordThree: w3_q <= cfg_wdata_i;
        CfgWordFour:  w4_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Unpack the six coefficients
  always_comb begin
    coeff_o.c1 = w1_q[15:1];
    coeff_o.c5 = {w1_q[0], w2_q[15:6]};
    coeff_o.c6 = w2_q[5:0];
    coeff_o.c4 = w3_q[15:6];
    coeff_o.c2 = {w3_q[5:0], w4_q[5:0]};
    coeff_o.c3 = w4_q[15:6];
  end

endmodule

@@ rtl/bpc_ctrl.sv @@
module bpc_ctrl import bpc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output pipe_ctrl_t ctrl_o
);

  logic [NumStages-1:0] valid_q, valid_d;
  logic [NumStages-1:0] ready;
  logic [NumStages-1:0] vin;

  // A stage may take a beat when empty or when the stage after it moves on
  always_comb begin
    ready[NumStages-1] = !valid_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
    vin = {valid_q[NumStages-2:0], in_valid_i};
    for (int k = 0; k < NumStages; k++) begin
      ctrl_o.load[k] = ready[k] && vin[k];
      valid_d[k]     = ready[k] ? vin[k] : valid_q[k];
    end
  end

  // Advance valid bits alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o  = !ready[0];
  assign out_valid_o = valid_q[NumStages-1];

endmodule

@@ rtl/bpc_dp.sv @@
module bpc_dp import bpc_pkg::*; (
  input  logic               clk_i,
  input  pipe_ctrl_t         ctrl_i,
  input  coeff_t             coeff_i,
  input  logic [15:0]        pressure_raw_i,
  input  logic [15:0]        temp_raw_i,
  output logic signed [23:0] pressure_pa_o,
  output logic signed [15:0] temp_tenths_c_o
);

  // ---------------- stage 1: temperature offset dT ----------------
  logic [15:0]        ut1;
  logic signed [16:0] s1_dt_d, s1_dt_q;
  logic [15:0]        s1_d1_q;

  always_comb begin
    ut1     = {2'b00, coeff_i.c5, 3'b000} + RefTempBase;
    s1_dt_d = $signed({1'b0, temp_raw_i}) - $signed({1'b0, ut1});
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[0]) begin
      s1_dt_q <= s1_dt_d;
      s1_d1_q <= pressure_raw_i;
    end
  end

  // ---------------- stage 2: first-order TEMP, OFF, SENS ----------------
  logic [6:0]         c6p50;
  logic signed [24:0] mul_t;
  logic signed [26:0] mul_o;
  logic signed [27:0] mul_s;
  logic signed [24:0] mul_t_sh;
  logic signed [26:0] mul_o_sh;
  logic signed [27:0] mul_s_sh;
  logic signed [15:0] s2_temp_d, s2_temp_q;
  logic signed [15:0] s2_off_d, s2_off_q;
  logic signed [17:0] s2_sens_d, s2_sens_q;
  logic [15:0]        s2_d1_q;

  always_comb begin
    c6p50    = {1'b0, coeff_i.c6} + TempSlopeOff;
    mul_t    = s1_dt_q * $signed({1'b0, c6p50});
    // C4 - 512 is C4 with its top bit flipped, read as signed
    mul_o    = s1_dt_q * $signed({~coeff_i.c4[9], coeff_i.c4[8:0]});
    mul_s    = s1_dt_q * $signed({1'b0, coeff_i.c3});
    mul_t_sh = mul_t >>> 10;
    mul_o_sh = mul_o >>> 12;
    mul_s_sh = mul_s >>> 10;
    s2_temp_d = $signed(mul_t_sh[15:0]) + TempBase;
    s2_off_d  = $signed({2'b00, coeff_i.c2, 2'b00}) + $signed(mul_o_sh[15:0]);
    s2_sens_d = $signed({3'b000, coeff_i.c1}) + $signed(mul_s_sh[17:0]) + SensBase;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[1]) begin
      s2_temp_q <= s2_temp_d;
      s2_off_q  <= s2_off_d;
      s2_sens_q <= s2_sens_d;
      s2_d1_q   <= s1_d1_q;
    end
  end

  // ---------------- stage 3: SENS product, cold-side square ----------------
  logic signed [16:0] d1_off;
  logic signed [34:0] s3_pm_d, s3_pm_q;
  logic signed [15:0] cold_diff;
  logic [12:0]        dd;
  logic [24:0]        s3_dsq_d, s3_dsq_q;
  logic signed [15:0] s3_off_q;
  logic signed [15:0] s3_temp_q;

  always_comb begin
    d1_off    = $signed({1'b0, s2_d1_q}) - PressRawBase;
    s3_pm_d   = s2_sens_q * d1_off;
    cold_diff = TempBase - s2_temp_q;
    // Only below 20.0 C does the correction apply; zero distance kills it
    dd        = (s2_temp_q < TempBase) ? cold_diff[12:0] : '0;
    s3_dsq_d  = 25'(dd) * 25'(dd);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[2]) begin
      s3_pm_q   <= s3_pm_d;
      s3_dsq_q  <= s3_dsq_d;
      s3_off_q  <= s2_off_q;
      s3_temp_q <= s2_temp_q;
    end
  end

  // ---------------- stage 4: first-order P, T2 ----------------
  logic signed [34:0] pm_sh;
  logic signed [20:0] x;
  logic signed [24:0] x10;
  logic signed [24:0] x10_sh;
  logic [6:0]         c6p24;
  logic [9:0]         corr_k;
  logic [34:0]        t2_prod;
  logic [34:0]        t2_sh;
  logic signed [18:0] s4_p_d, s4_p_q;
  logic [14:0]        s4_t2_d, s4_t2_q;
  logic signed [15:0] s4_temp_q;

  always_comb begin
    pm_sh   = s3_pm_q >>> 14;
    x       = $signed(pm_sh[20:0]) - 21'(s3_off_q);
    x10     = 25'(x) * 25'sd10;
    x10_sh  = x10 >>> 5;
    s4_p_d  = $signed(x10_sh[18:0]) + PressBase;
    c6p24   = {1'b0, coeff_i.c6} + CorrSlopeOff;
    corr_k  = 10'(c6p24) * CorrGain;
    t2_prod = 35'(corr_k) * 35'(s3_dsq_q);
    t2_sh   = t2_prod >> 20;
    s4_t2_d = t2_sh[14:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[3]) begin
      s4_p_q    <= s4_p_d;
      s4_t2_q   <= s4_t2_d;
      s4_temp_q <= s3_temp_q;
    end
  end

  // ---------------- stage 5: P2 product, final temperature ----------------
  logic [16:0]        t2x3;
  logic signed [18:0] p_knee;
  logic signed [35:0] s5_pp_d, s5_pp_q;
  logic signed [16:0] temp_f;
  logic signed [15:0] s5_temp_d, s5_temp_q;
  logic signed [18:0] s5_p_q;

  always_comb begin
    t2x3    = {1'b0, s4_t2_q, 1'b0} + {2'b00, s4_t2_q};
    p_knee  = s4_p_q - PressKnee;
    s5_pp_d = $signed({1'b0, t2x3}) * p_knee;
    temp_f  = 17'(s4_temp_q) - $signed({2'b00, s4_t2_q});
    // Saturate temperature to its field range
    if (temp_f > TempMax) begin
      s5_temp_d = TempMax[15:0];
    end else if (temp_f < TempMin) begin
      s5_temp_d = TempMin[15:0];
    end else begin
      s5_temp_d = temp_f[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[4]) begin
      s5_pp_q   <= s5_pp_d;
      s5_p_q    <= s4_p_q;
      s5_temp_q <= s5_temp_d;
    end
  end

  // ---------------- stage 6: output register ----------------
  logic signed [35:0] pp_sh;
  logic signed [21:0] p_fin;
  logic signed [25:0] pa;
  logic signed [23:0] s6_pa_d, s6_pa_q;
  logic signed [15:0] s6_temp_q;

  always_comb begin
    pp_sh = s5_pp_q >>> 14;
    p_fin = 22'(s5_p_q) - $signed(pp_sh[21:0]);
    pa    = 26'(p_fin) * 26'sd10;
    // Saturate pressure to its field range
    if (pa > PressMax) begin
      s6_pa_d = PressMax[23:0];
    end else if (pa < PressMin) begin
      s6_pa_d = PressMin[23:0];
    end else begin
      s6_pa_d = pa[23:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[5]) begin
      s6_pa_q   <= s6_pa_d;
      s6_temp_q <= s5_temp_q;
    end
  end

  assign pressure_pa_o   = s6_pa_q;
  assign temp_tenths_c_o = s6_temp_q;

endmodule

@@ rtl/baro_pressure_temp_compensation_core.sv @@
// Barometric pressure and temperature compensation core.
// Configuration: four 16-bit calibration words, reset to zero, are written
// through cfg_we_i, cfg_idx_i (0 to 3, other indexes are ignored) and
// cfg_wdata_i, by the user only while the core is idle (not enforced here).
// Input channel: one beat carries a raw pressure word and a raw temperature
// word (in_valid_i / in_stall_o). Output channel: one beat carries pressure
// in pascal and temperature in tenths of a degree Celsius, both saturated
// (out_valid_o / out_stall_i).
// An accepted input beat passes through the six register stages of the
// datapath on its way to the output.
// Throughput: one beat per cycle while out_stall_i is low, all stages moving.
// When the receiver stalls, the output register holds its beat unchanged;
// empty stages behind it keep filling, and once the pipeline is full the
// input channel stalls. Nothing is dropped or repeated.
// Reset clears all valid bits and the calibration words; the core accepts
// input as soon as reset is released.
module baro_pressure_temp_compensation_core import bpc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [15:0]         pressure_raw_i,
  input  logic [15:0]         temp_raw_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [23:0]  pressure_pa_o,
  output logic signed [15:0]  temp_tenths_c_o
);

  coeff_t     coeff;
  pipe_ctrl_t ctrl;

  bpc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .coeff_o     (coeff)
  );

  bpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctrl_o      (ctrl)
  );

  bpc_dp u_dp (
    .clk_i           (clk_i),
    .ctrl_i          (ctrl),
    .coeff_i         (coeff),
    .pressure_raw_i  (pressure_raw_i),
    .temp_raw_i      (temp_raw_i),
    .pressure_pa_o   (pressure_pa_o),
    .temp_tenths_c_o (temp_tenths_c_o)
  );

endmodule
